@@ sv/hwt_pkg.sv @@
package hwt_pkg;

	localparam int BLOCK_LENGTH = 32;
	localparam int DATA_W       = 32;
	localparam int ADDR_W       = $clog2(BLOCK_LENGTH);

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [1:0] {
		SRC_A,
		SRC_B,
		SRC_ZERO
	} src_t;

	typedef struct packed {
		logic lat_a;
		logic sel_sample;
		logic ld_out;
		src_t src;
	} ctrl_t;

	// The last level whose span covers position k decides where its final value lives:
	// a difference (B store) or a sum that no later level overwrote (A store).
	function automatic src_t coef_src(input addr_t k);
		src_t src;
		src = SRC_ZERO;
		for (int p = BLOCK_LENGTH >> 1; p >= 1; p = p >> 1) begin
			if (int'(k) < 2 * p) begin
				src = (int'(k) >= p) ? SRC_B : SRC_A;
			end
		end
		return src;
	endfunction

endpackage

@@ sv/hwt_ram.sv @@
module hwt_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ sv/hwt_datapath.sv @@
module hwt_datapath
	import hwt_pkg::*;
(
	input  logic  clk,
	input  ctrl_t ctrl,
	input  data_t sample,
	input  data_t a_rdata,
	input  data_t b_rdata,
	output data_t a_wdata,
	output data_t b_wdata,
	output data_t coefficient
);

	data_t a_q;
	data_t coef_q;
	data_t sum;
	data_t diff;
	data_t coef_d;

	always_ff @(posedge clk) begin
		if (ctrl.lat_a) begin
			a_q <= a_rdata;
		end
	end

	// butterfly: first operand latched, second straight from the read port
	assign sum  = a_q + a_rdata;
	assign diff = a_q - a_rdata;

	assign a_wdata = ctrl.sel_sample ? sample : sum;
	assign b_wdata = diff;

	always_comb begin
		unique case (ctrl.src)
			SRC_A:    coef_d = a_rdata;
			SRC_B:    coef_d = b_rdata;
			SRC_ZERO: coef_d = '0;
			default:  coef_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_out) begin
			coef_q <= coef_d;
		end
	end

	assign coefficient = coef_q;

endmodule

@@ sv/hwt_seq.sv @@
module hwt_seq
	import hwt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  sample_valid,
	output logic  sample_ready,
	output logic  coefficient_valid,
	input  logic  coefficient_ready,
	output logic  last_coefficient,
	output logic  a_we,
	output addr_t a_waddr,
	output addr_t a_raddr,
	output logic  b_we,
	output addr_t b_waddr,
	output addr_t b_raddr,
	output ctrl_t ctrl
);

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_RD0  = 3'd1;
	localparam logic [2:0] ST_RD1  = 3'd2;
	localparam logic [2:0] ST_WR   = 3'd3;
	localparam logic [2:0] ST_ERD  = 3'd4;
	localparam logic [2:0] ST_ELD  = 3'd5;

	localparam addr_t LAST_IDX   = ADDR_W'(BLOCK_LENGTH - 1);
	localparam addr_t FIRST_HALF = ADDR_W'(BLOCK_LENGTH / 2);
	localparam addr_t ONE        = ADDR_W'(1);

	logic [2:0] state_q, state_d;
	addr_t      load_cnt_q, load_cnt_d;
	addr_t      half_q, half_d;
	addr_t      pair_q, pair_d;
	addr_t      emit_q, emit_d;
	logic       out_valid_q, out_valid_d;
	logic       last_q, last_d;
	src_t       src_s1, src_d;
	logic       last_s1, last_sd;
	logic       sample_req;
	logic       out_free;

	assign sample_ready      = (state_q == ST_LOAD);
	assign sample_req        = sample_valid && sample_ready;
	assign out_free          = !out_valid_q || coefficient_ready;
	assign coefficient_valid = out_valid_q;
	assign last_coefficient  = last_q;
	assign b_raddr           = emit_q;

	always_comb begin
		state_d         = state_q;
		load_cnt_d      = load_cnt_q;
		half_d          = half_q;
		pair_d          = pair_q;
		emit_d          = emit_q;
		src_d           = src_s1;
		last_sd         = last_s1;
		a_we            = 1'b0;
		a_waddr         = load_cnt_q;
		a_raddr         = emit_q;
		b_we            = 1'b0;
		b_waddr         = half_q + pair_q;
		ctrl.lat_a      = 1'b0;
		ctrl.sel_sample = 1'b0;
		ctrl.ld_out     = 1'b0;
		ctrl.src        = src_s1;

		unique case (state_q)
			ST_LOAD: begin
				ctrl.sel_sample = 1'b1;
				if (sample_req) begin
					a_we = 1'b1;
					if (load_cnt_q == LAST_IDX) begin
						load_cnt_d = '0;
						half_d     = FIRST_HALF;
						pair_d     = '0;
						state_d    = ST_RD0;
					end else begin
						load_cnt_d = load_cnt_q + ONE;
					end
				end
			end
			ST_RD0: begin
				a_raddr = {pair_q[ADDR_W-2:0], 1'b0};
				state_d = ST_RD1;
			end
			ST_RD1: begin
				a_raddr    = {pair_q[ADDR_W-2:0], 1'b1};
				ctrl.lat_a = 1'b1;
				state_d    = ST_WR;
			end
			ST_WR: begin
				// sum in place over the sample store, difference to its final slot
				a_we    = 1'b1;
				a_waddr = pair_q;
				b_we    = 1'b1;
				if (pair_q == half_q - ONE) begin
					pair_d = '0;
					if (half_q == ONE) begin
						emit_d  = '0;
						state_d = ST_ERD;
					end else begin
						half_d  = half_q >> 1;
						state_d = ST_RD0;
					end
				end else begin
					pair_d  = pair_q + ONE;
					state_d = ST_RD0;
				end
			end
			ST_ERD: begin
				if (out_free) begin
					src_d   = coef_src(emit_q);
					last_sd = (emit_q == LAST_IDX);
					state_d = ST_ELD;
				end
			end
			ST_ELD: begin
				ctrl.ld_out = 1'b1;
				if (last_s1) begin
					emit_d  = '0;
					state_d = ST_LOAD;
				end else begin
					emit_d  = emit_q + ONE;
					state_d = ST_ERD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		last_d      = last_q;
		if (ctrl.ld_out) begin
			out_valid_d = 1'b1;
			last_d      = last_s1;
		end else if (out_valid_q && coefficient_ready) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			load_cnt_q  <= '0;
			half_q      <= FIRST_HALF;
			pair_q      <= '0;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			load_cnt_q  <= load_cnt_d;
			half_q      <= half_d;
			pair_q      <= pair_d;
			emit_q      <= emit_d;
			out_valid_q <= out_valid_d;
			last_q      <= last_d;
		end
	end

	always_ff @(posedge clk) begin
		src_s1  <= src_d;
		last_s1 <= last_sd;
	end

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ld_out |-> !out_valid_q)
		else $error("output register loaded while a request is pending");

	a_pair_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD0 || state_q == ST_RD1 || state_q == ST_WR)
		|-> (half_q != '0 && pair_q < half_q))
		else $error("butterfly pair index out of level range");

	a_block_start: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_req && load_cnt_q == LAST_IDX) |=> (state_q == ST_RD0 && pair_q == '0))
		else $error("transform did not start after the final sample");

endmodule

@@ sv/haar_wavelet_transform.sv @@
// channel      | handshake                               | payload
// sample       | sample_valid / sample_ready             | sample[31:0]
// coefficient  | coefficient_valid / coefficient_ready   | coefficient[31:0], last_coefficient
//
// Load: one sample per cycle, BLOCK_LENGTH requests.
// Transform: BLOCK_LENGTH-1 butterflies for a power-of-two length, each through ST_RD0,
// ST_RD1 and ST_WR, as the sample store has a single read port (two operand reads, one write).
// Emit: each coefficient is read in ST_ERD once the output register is free, then loaded in ST_ELD.
// Stores need no clearing after reset; the next block loads while the last coefficient waits.
module haar_wavelet_transform
	import hwt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_ready,
	input  logic [31:0] sample,
	output logic        coefficient_valid,
	input  logic        coefficient_ready,
	output logic [31:0] coefficient,
	output logic        last_coefficient
);

	ctrl_t ctrl;
	logic  a_we;
	logic  b_we;
	addr_t a_waddr;
	addr_t a_raddr;
	addr_t b_waddr;
	addr_t b_raddr;
	data_t a_wdata;
	data_t b_wdata;
	data_t a_rdata;
	data_t b_rdata;

	hwt_seq u_seq (
		.clk               (clk),
		.arst_n            (arst_n),
		.sample_valid      (sample_valid),
		.sample_ready      (sample_ready),
		.coefficient_valid (coefficient_valid),
		.coefficient_ready (coefficient_ready),
		.last_coefficient  (last_coefficient),
		.a_we              (a_we),
		.a_waddr           (a_waddr),
		.a_raddr           (a_raddr),
		.b_we              (b_we),
		.b_waddr           (b_waddr),
		.b_raddr           (b_raddr),
		.ctrl              (ctrl)
	);

	hwt_ram #(
		.DEPTH (BLOCK_LENGTH),
		.WIDTH (DATA_W)
	) u_sample_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	hwt_ram #(
		.DEPTH (BLOCK_LENGTH),
		.WIDTH (DATA_W)
	) u_coef_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	hwt_datapath u_datapath (
		.clk         (clk),
		.ctrl        (ctrl),
		.sample      (sample),
		.a_rdata     (a_rdata),
		.b_rdata     (b_rdata),
		.a_wdata     (a_wdata),
		.b_wdata     (b_wdata),
		.coefficient (coefficient)
	);

endmodule

@@ tb/sv/tb_haar_wavelet_transform.sv @@
module tb_haar_wavelet_transform;
	import hwt_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 5;
	localparam int RAND_BLOCKS  = 9;
	localparam int DRAIN_BLOCK  = 4;
	localparam int HOLD_AFTER   = 40;
	localparam int HOLD_CYCLES  = 500;
	localparam int TAIL_CYCLES  = 200;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		data_t value;
		logic  drain_first;
	} sample_req_t;

	typedef struct packed {
		data_t value;
		logic  last;
	} coef_t;

	logic        clk               = 1'b0;
	logic        arst_n            = 1'b0;
	logic        sample_valid      = 1'b0;
	logic        sample_ready;
	logic [31:0] sample            = '0;
	logic        coefficient_valid;
	logic        coefficient_ready = 1'b0;
	logic [31:0] coefficient;
	logic        last_coefficient;

	sample_req_t sample_queue[$];
	coef_t       pending_coefs[$];
	data_t       block_samples[BLOCK_LENGTH];
	int          fill_count     = 0;
	int          accepted_count = 0;
	int          cycle_count    = 0;
	int          error_count    = 0;
	bit          sample_fire    = 1'b0;
	int          send_gap       = 0;
	int          send_calm      = 0;
	int          recv_gap       = 0;
	int          recv_calm      = 0;
	int          hold_left      = 0;
	bit          hold_done      = 1'b0;

	haar_wavelet_transform uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.sample_valid     (sample_valid),
		.sample_ready     (sample_ready),
		.sample           (sample),
		.coefficient_valid(coefficient_valid),
		.coefficient_ready(coefficient_ready),
		.coefficient      (coefficient),
		.last_coefficient (last_coefficient)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// full multi-level transform of block_samples, Mallat order, queued for checking
	function automatic void predict_block_coefs();
		data_t work[BLOCK_LENGTH];
		data_t coefs[BLOCK_LENGTH];
		coef_t c;
		for (int i = 0; i < BLOCK_LENGTH; i++) begin
			work[i]  = block_samples[i];
			coefs[i] = '0;
		end
		for (int p = BLOCK_LENGTH / 2; p >= 1; p = p / 2) begin
			for (int i = 0; i < p; i++) begin
				coefs[i]     = work[2*i] + work[2*i+1];
				coefs[p + i] = work[2*i] - work[2*i+1];
			end
			for (int i = 0; i < 2 * p; i++)
				work[i] = coefs[i];
		end
		for (int k = 0; k < BLOCK_LENGTH; k++) begin
			c.value = coefs[k];
			c.last  = (k == BLOCK_LENGTH - 1);
			pending_coefs.push_back(c);
		end
	endfunction

	task automatic report_error(input string msg);
		error_count++;
		$display("cycle %0d: %s", cycle_count, msg);
	endtask

	// request driver
	always @(negedge clk) begin : sample_drv
		logic  nxt_valid;
		data_t nxt_data;
		nxt_valid = sample_valid;
		nxt_data  = sample;
		if (arst_n && (!sample_valid || sample_fire)) begin
			nxt_valid = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (sample_queue.size() > 0 && (!sample_queue[0].drain_first ||
					(pending_coefs.size() == 0 && fill_count == 0))) begin
				nxt_valid = 1'b1;
				nxt_data  = sample_queue[0].value;
				sample_queue.delete(0);
				if (send_calm > 0) begin
					send_calm--;
					send_gap = 0;
				end else begin
					send_gap = pick_gap();
					if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(20, 60);
				end
			end
		end
		sample_valid <= nxt_valid;
		sample       <= nxt_data;
	end

	// receiver, with one long hold-off once HOLD_AFTER samples have been accepted
	always @(negedge clk) begin : coef_rcv
		logic nxt_ready;
		nxt_ready = 1'b0;
		if (arst_n) begin
			if (!hold_done && accepted_count >= HOLD_AFTER) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
			end else if (recv_gap > 0) begin
				recv_gap--;
			end else begin
				nxt_ready = 1'b1;
				if (recv_calm > 0) begin
					recv_calm--;
					recv_gap = 0;
				end else begin
					recv_gap = pick_gap();
					if ($urandom_range(0, 39) == 0) recv_calm = $urandom_range(20, 60);
				end
			end
		end
		coefficient_ready <= nxt_ready;
	end

	// prediction on accepted samples, checking of accepted coefficients
	always @(posedge clk) begin : mon
		coef_t want;
		cycle_count++;
		sample_fire = arst_n && sample_valid && sample_ready;
		if (sample_fire) begin
			block_samples[fill_count] = sample;
			fill_count++;
			accepted_count++;
			if (fill_count == BLOCK_LENGTH) begin
				predict_block_coefs();
				fill_count = 0;
			end
		end
		if (arst_n && coefficient_valid && coefficient_ready) begin
			if (pending_coefs.size() == 0) begin
				report_error($sformatf("unexpected coefficient %h last %b",
					coefficient, last_coefficient));
			end else begin
				want = pending_coefs.pop_front();
				if (coefficient !== want.value)
					report_error($sformatf("coefficient %h, expected %h",
						coefficient, want.value));
				if (last_coefficient !== want.last)
					report_error($sformatf("last_coefficient %b, expected %b",
						last_coefficient, want.last));
			end
		end
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout");
			$display("** haar_wavelet_transform: FAILED **");
			$finish;
		end
	end

	initial begin : stim
		sample_req_t req;
		int          style;
		data_t       fixed;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed block: extremes, wrap of sums and differences
		for (int i = 0; i < BLOCK_LENGTH; i++) begin
			req.drain_first = 1'b0;
			case (i % 16)
				0, 3:    req.value = 32'h0000_0000;
				1, 2:    req.value = 32'hFFFF_FFFF;
				4, 5:    req.value = 32'h8000_0000;
				6:       req.value = 32'h7FFF_FFFF;
				7:       req.value = 32'h8000_0000;
				8, 11:   req.value = 32'h0000_0001;
				9, 10:   req.value = 32'hFFFF_FFFF;
				12, 15:  req.value = 32'hAAAA_AAAA;
				default: req.value = 32'h5555_5555;
			endcase
			if (i >= 16 && i % 2 == 0) req.value = 32'hFFFF_FFFF;
			sample_queue.push_back(req);
		end

		for (int b = 0; b < RAND_BLOCKS; b++) begin
			style = $urandom_range(0, 4);
			fixed = $urandom;
			for (int i = 0; i < BLOCK_LENGTH; i++) begin
				req.drain_first = (b == DRAIN_BLOCK && i == 0);
				if (style == 0) begin
					req.value = fixed;
				end else begin
					case ($urandom_range(0, 9))
						0:       req.value = '0;
						1:       req.value = '1;
						2:       req.value = 32'h8000_0000 ^ $urandom_range(0, 15);
						3:       req.value = $urandom_range(0, 255);
						default: req.value = $urandom;
					endcase
				end
				sample_queue.push_back(req);
			end
		end

		while (sample_queue.size() != 0 || sample_valid) @(posedge clk);
		while (pending_coefs.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (error_count == 0) begin
			$display("** haar_wavelet_transform: PASSED **");
		end else begin
			$display("** haar_wavelet_transform: FAILED **");
		end
		$finish;
	end

endmodule
